[hw/rtl/mlsf_pkg.sv]
// Shared widths, constants, types and the flood mask function of the MAC learning forwarder.
`timescale 1ns / 1ps

package mlsf_pkg;

  localparam int MAC_W          = 48;
  localparam int PORT_IDX_W     = 3;
  localparam int PORT_W         = 4;
  localparam int MASK_W         = 8;
  localparam int CFG_W          = 4;
  localparam int NUM_PORTS      = 8;
  localparam int ENTRY_W        = MAC_W + PORT_W;
  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [CFG_W-1:0] PORT_COUNT_RST = CFG_W'(8);
  localparam logic [MAC_W-1:0] BCAST_MAC      = {MAC_W{1'b1}};

  typedef struct packed {
    logic              done;
    logic              src_hit;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } srch_res_t;

  function automatic logic [MASK_W-1:0] flood_mask(input logic [CFG_W-1:0] pc,
                                                   input logic [PORT_IDX_W-1:0] ip);
    logic [MASK_W-1:0] m;
    int unsigned       lim;
    m   = '0;
    lim = int'(pc);
    if (lim > NUM_PORTS) lim = NUM_PORTS;
    if (lim > MASK_W) lim = MASK_W;
    for (int i = 0; i < MASK_W; i++) begin
      if ((i < int'(lim)) && (i != int'(ip))) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

[hw/rtl/mlsf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mlsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/mlsf_search.sv]
// Table scan engine that reads every valid entry once and matches source and destination.
`timescale 1ns / 1ps

module mlsf_search
  import mlsf_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] used,
  input  logic [MAC_W-1:0]                   src,
  input  logic [MAC_W-1:0]                   dst,
  output logic                               rd_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
  input  logic [ENTRY_W-1:0]                 rd_data,
  output srch_res_t                          res
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic          issuing;
  logic [CW-1:0] issue_cnt;
  logic          pend;
  logic          pend_last;
  logic          last_issue;
  logic [MAC_W-1:0]  rd_mac;
  logic [PORT_W-1:0] rd_port;

  assign last_issue = (issue_cnt + CW'(1)) == used;
  assign rd_en      = issuing;
  assign rd_addr    = issue_cnt[AW-1:0];
  assign rd_mac     = rd_data[ENTRY_W-1 -: MAC_W];
  assign rd_port    = rd_data[PORT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing      <= 1'b0;
      issue_cnt    <= '0;
      pend         <= 1'b0;
      pend_last    <= 1'b0;
      res.done     <= 1'b0;
      res.src_hit  <= 1'b0;
      res.dst_hit  <= 1'b0;
      res.dst_port <= '0;
    end else begin
      pend      <= issuing;
      pend_last <= issuing && last_issue;
      res.done  <= (pend && pend_last) || (start && (used == '0));
      if (start) begin
        issuing     <= (used != '0);
        issue_cnt   <= '0;
        res.src_hit <= 1'b0;
        res.dst_hit <= 1'b0;
      end else begin
        if (issuing) begin
          issue_cnt <= issue_cnt + CW'(1);
          if (last_issue) issuing <= 1'b0;
        end
        if (pend) begin
          if (rd_mac == src) res.src_hit <= 1'b1;
          if ((rd_mac == dst) && !res.dst_hit) begin
            res.dst_hit  <= 1'b1;
            res.dst_port <= rd_port;
          end
        end
      end
    end
  end

endmodule

[hw/rtl/mac_learning_switch_forwarder.sv]
// Top level of the MAC learning forwarder: control, learning, configuration and result word.
//
// Channel  Handshake           Payload
// in       in_valid/in_stall   src_mac, dst_mac, in_port
// out      out_valid/out_stall out_mask, flooded, learned, learn_failed
// cfg      cfg_valid/cfg_ready cfg_data (port_count)
//
// Each header is scanned against all used entries before the next is taken: the table RAM's
// read port gives one entry a cycle, followed by the read, compare, decision and idle steps.
// An empty table skips the scan; a full table holds TABLE_ENTRIES entries, 64 by default.
// Reset clears the fill count but not the table RAM, so no clearing pass runs and headers are taken at once.
// A result word waits in the output register while the next header is searched.
// A stalled output holds the block in its decision step until the word is taken.
`timescale 1ns / 1ps

module mac_learning_switch_forwarder
  import mlsf_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MAC_W-1:0]      src_mac,
  input  logic [MAC_W-1:0]      dst_mac,
  input  logic [PORT_IDX_W-1:0] in_port,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MASK_W-1:0]     out_mask,
  output logic                  flooded,
  output logic                  learned,
  output logic                  learn_failed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]            state;
  logic [CW-1:0]         used;
  logic [CFG_W-1:0]      port_count;
  logic [MAC_W-1:0]      src_r;
  logic [MAC_W-1:0]      dst_r;
  logic [PORT_IDX_W-1:0] port_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  decide;
  logic                  has_room;
  logic                  do_learn;
  logic                  dst_known;
  logic                  do_flood;
  logic [PORT_W-1:0]     fwd_port;
  logic [MASK_W-1:0]     mask_next;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  srch_res_t             srch;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign decide    = (state == ST_DECIDE) && out_free;

  assign has_room  = (used != CW'(TABLE_ENTRIES));
  assign do_learn  = !srch.src_hit && has_room;
  assign dst_known = srch.dst_hit || (do_learn && (dst_r == src_r));
  assign do_flood  = (dst_r == BCAST_MAC) || !dst_known;
  assign fwd_port  = srch.dst_hit ? srch.dst_port : PORT_W'(port_r);

  always_comb begin
    if (do_flood) begin
      mask_next = flood_mask(port_count, port_r);
    end else if (fwd_port[PORT_W-1]) begin
      mask_next = '0;
    end else begin
      mask_next = MASK_W'(1) << fwd_port[PORT_IDX_W-1:0];
    end
  end

  mlsf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (decide && do_learn),
    .wr_addr(used[AW-1:0]),
    .wr_data({src_r, PORT_W'(port_r)}),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mlsf_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .used   (used),
    .src    (src_r),
    .dst    (dst_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (srch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      port_count <= PORT_COUNT_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) port_count <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (srch.done) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (do_learn) used <= used + CW'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r  <= src_mac;
      dst_r  <= dst_mac;
      port_r <= in_port;
    end
    if (decide) begin
      out_mask     <= mask_next;
      flooded      <= do_flood;
      learned      <= do_learn;
      learn_failed <= !srch.src_hit && !has_room;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(learned && learn_failed))
    else $error("learned and learn_failed set together");

  assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !flooded) |-> $onehot0(out_mask))
    else $error("forwarded word with more than one port");

  assert property (@(posedge clk) disable iff (rst)
    srch.done |-> (state == ST_SEARCH))
    else $error("search finished outside the search step");

  assert property (@(posedge clk) disable iff (rst)
    decide |=> (out_valid && (used == $past(used) + CW'($past(do_learn)))))
    else $error("decision step did not update result and fill count");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the MAC learning forwarder, with directed and random frame headers.

module tb;
  import mlsf_pkg::*;

  localparam int TBL_DEPTH    = TABLE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 70;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              flooded;
    logic              learned;
    logic              learn_failed;
  } fwd_decision_t;

  localparam logic [MAC_W-1:0] MAC_A = 48'h0200_0000_000a;
  localparam logic [MAC_W-1:0] MAC_B = 48'h0200_0000_000b;
  localparam logic [MAC_W-1:0] MAC_C = 48'h0200_0000_000c;
  localparam logic [MAC_W-1:0] MAC_D = 48'h0200_0000_000d;
  localparam logic [MAC_W-1:0] MAC_E = 48'h0200_0000_000e;
  localparam logic [MAC_W-1:0] MAC_F = 48'h0200_0000_000f;
  localparam logic [MAC_W-1:0] MAC_G = 48'h0200_0000_0010;
  localparam logic [MAC_W-1:0] MAC_U = 48'h5a5a_a5a5_0f0f;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [MAC_W-1:0]      src_mac      = '0;
  logic [MAC_W-1:0]      dst_mac      = '0;
  logic [PORT_IDX_W-1:0] in_port      = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [MASK_W-1:0]     out_mask;
  logic                  flooded;
  logic                  learned;
  logic                  learn_failed;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data     = '0;

  logic [MAC_W-1:0]  fdb_mac  [TBL_DEPTH];
  logic [PORT_W-1:0] fdb_port [TBL_DEPTH];
  int unsigned       fdb_used = 0;
  logic [CFG_W-1:0]  active_ports = PORT_COUNT_RST;

  fwd_decision_t     pending_decisions[$];
  logic [MAC_W-1:0]  mac_pool[$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int errors     = 0;
  int sent       = 0;
  int checked    = 0;
  int floods     = 0;
  int hits       = 0;
  int fails      = 0;

  always #5 clk = ~clk;

  mac_learning_switch_forwarder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .src_mac      (src_mac),
    .dst_mac      (dst_mac),
    .in_port      (in_port),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mask     (out_mask),
    .flooded      (flooded),
    .learned      (learned),
    .learn_failed (learn_failed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  function automatic logic fdb_lookup(input logic [MAC_W-1:0] mac,
                                      output logic [PORT_W-1:0] port);
    port = '0;
    for (int i = 0; i < int'(fdb_used); i++) begin
      if (fdb_mac[i] == mac) begin
        port = fdb_port[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic fwd_decision_t forward_predict(input logic [MAC_W-1:0] s,
                                                    input logic [MAC_W-1:0] d,
                                                    input logic [PORT_IDX_W-1:0] p);
    fwd_decision_t     r;
    logic [PORT_W-1:0] hit_port;
    int                lim;
    r = '0;
    if (!fdb_lookup(s, hit_port)) begin
      if (fdb_used < TBL_DEPTH) begin
        fdb_mac[fdb_used]  = s;
        fdb_port[fdb_used] = PORT_W'(p);
        fdb_used++;
        r.learned = 1'b1;
      end else begin
        r.learn_failed = 1'b1;
      end
    end
    if (d == BCAST_MAC || !fdb_lookup(d, hit_port)) begin
      r.flooded = 1'b1;
      lim = int'(active_ports);
      if (lim > NUM_PORTS) lim = NUM_PORTS;
      if (lim > MASK_W) lim = MASK_W;
      for (int i = 0; i < MASK_W; i++) begin
        if (i < lim && i != int'(p)) r.mask[i] = 1'b1;
      end
    end else if (int'(hit_port) < MASK_W) begin
      r.mask[hit_port] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch on %s at word %0d: got %0h, expected %0h", what, checked, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_word
    fwd_decision_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected word",
                        64'({out_mask, flooded, learned, learn_failed}), 64'(0));
      end else begin
        want = pending_decisions.pop_front();
        if (out_mask !== want.mask) begin
          report_mismatch("out_mask", 64'(out_mask), 64'(want.mask));
        end
        if (flooded !== want.flooded) begin
          report_mismatch("flooded", 64'(flooded), 64'(want.flooded));
        end
        if (learned !== want.learned) begin
          report_mismatch("learned", 64'(learned), 64'(want.learned));
        end
        if (learn_failed !== want.learn_failed) begin
          report_mismatch("learn_failed", 64'(learn_failed), 64'(want.learn_failed));
        end
        if (want.flooded) floods++;
        else hits++;
        if (want.learn_failed) fails++;
      end
      checked++;
    end
  end

  task automatic send_header(input logic [MAC_W-1:0] s, input logic [MAC_W-1:0] d,
                             input logic [PORT_IDX_W-1:0] p);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_mac  <= s;
    dst_mac  <= d;
    in_port  <= p;
    pending_decisions.push_back(forward_predict(s, d, p));
    sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_quiet();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  task automatic write_port_count(input logic [CFG_W-1:0] v);
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_ports = v;
  endtask

  function automatic logic [MAC_W-1:0] fresh_mac();
    logic [MAC_W-1:0] m;
    m = MAC_W'({$urandom, $urandom});
    mac_pool.push_back(m);
    return m;
  endfunction

  task automatic send_random_header();
    logic [MAC_W-1:0] s;
    logic [MAC_W-1:0] d;
    int unsigned      pick;
    if (mac_pool.size() == 0 || $urandom_range(99) < 30) s = fresh_mac();
    else s = mac_pool[$urandom_range(mac_pool.size() - 1)];
    pick = $urandom_range(99);
    if (pick < 12) d = BCAST_MAC;
    else if (pick < 22) d = s;
    else if (pick < 75) d = mac_pool[$urandom_range(mac_pool.size() - 1)];
    else d = fresh_mac();
    send_header(s, d, PORT_IDX_W'($urandom_range(7)));
  endtask

  task automatic run_phase(input int n, input int ip, input int sp, input logic [CFG_W-1:0] pc);
    write_port_count(pc);
    idle_pct  = ip;
    stall_pct = sp;
    repeat (n) send_random_header();
  endtask

  task automatic test_learning_and_flooding();
    write_port_count(CFG_W'(8));
    send_header(MAC_A, BCAST_MAC, 3'd0);
    send_header(MAC_B, MAC_A, 3'd7);
    send_header(MAC_A, MAC_B, 3'd0);
    send_header(MAC_D, MAC_U, 3'd2);
    send_header(BCAST_MAC, MAC_U, 3'd5);
    send_header(MAC_D, BCAST_MAC, 3'd2);
    send_header(48'h0, BCAST_MAC, 3'd7);
  endtask

  task automatic test_source_equals_destination();
    send_header(MAC_C, MAC_C, 3'd3);
    send_header(MAC_C, MAC_C, 3'd6);
  endtask

  task automatic test_port_count_limits();
    write_port_count(CFG_W'(1));
    send_header(MAC_E, MAC_U, 3'd0);
    send_header(MAC_E, MAC_U, 3'd1);
    write_port_count(CFG_W'(0));
    send_header(MAC_F, MAC_U, 3'd4);
    write_port_count(CFG_W'(15));
    send_header(MAC_F, MAC_U, 3'd7);
    write_port_count(CFG_W'(9));
    send_header(MAC_F, BCAST_MAC, 3'd0);
  endtask

  task automatic test_inactive_ports();
    write_port_count(CFG_W'(3));
    send_header(MAC_G, MAC_U, 3'd6);
    send_header(MAC_G, MAC_B, 3'd1);
    send_header(MAC_G, 48'h0, 3'd7);
  endtask

  task automatic test_random_traffic();
    run_phase(120, 0, 0, CFG_W'(8));
    run_phase(60, 68, 0, CFG_W'($urandom_range(15)));
    wait_quiet();
    repeat (60) send_random_header();
    run_phase(120, 0, 68, CFG_W'($urandom_range(15)));
    run_phase(60, 27, 27, CFG_W'($urandom_range(1, 8)));
    run_phase(60, 27, 27, CFG_W'(8));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_learning_and_flooding();
    test_source_equals_destination();
    test_port_count_limits();
    test_inactive_ports();
    test_random_traffic();
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_decisions.size() != 0) begin
      report_mismatch("words never delivered", 64'(pending_decisions.size()), 64'(0));
    end
    $display("tb: %0d headers sent over directed cases and five traffic phases, %0d words checked",
             sent, checked);
    $display("tb: %0d floods, %0d table hits, %0d learn failures, %0d entries learned",
             floods, hits, fails, fdb_used);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
